/* rtl/mmfm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package mmfm_pkg;

	// Item kinds on the input channel
	typedef enum logic [1:0] {
		KIND_READ  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_TICK  = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	localparam int PREAMBLE_BITS = 32;

	localparam int CELL_W = 7;
	localparam int ADDR_W = 10;
	localparam int DATA_W = 16;

	// Cell numbers of the frame landmarks
	localparam logic [CELL_W-1:0] CELL_START0   = CELL_W'(PREAMBLE_BITS);
	localparam logic [CELL_W-1:0] CELL_START1   = CELL_W'(PREAMBLE_BITS + 1);
	localparam logic [CELL_W-1:0] CELL_OP0      = CELL_W'(PREAMBLE_BITS + 2);
	localparam logic [CELL_W-1:0] CELL_OP1      = CELL_W'(PREAMBLE_BITS + 3);
	localparam logic [CELL_W-1:0] CELL_ADDR_LO  = CELL_W'(PREAMBLE_BITS + 4);
	localparam logic [CELL_W-1:0] CELL_ADDR_HI  = CELL_W'(PREAMBLE_BITS + 13);
	localparam logic [CELL_W-1:0] CELL_RD_LO    = CELL_W'(PREAMBLE_BITS + 15);
	localparam logic [CELL_W-1:0] CELL_RD_HI    = CELL_W'(PREAMBLE_BITS + 30);
	localparam logic [CELL_W-1:0] CELL_WR_LO    = CELL_W'(PREAMBLE_BITS + 16);
	localparam logic [CELL_W-1:0] CELL_WR_HI    = CELL_W'(PREAMBLE_BITS + 31);
	localparam logic [CELL_W-1:0] CELL_RD_LAST  = CELL_W'(PREAMBLE_BITS + 31);
	localparam logic [CELL_W-1:0] CELL_WR_LAST  = CELL_W'(PREAMBLE_BITS + 32);

endpackage
`default_nettype wire

/* rtl/mdio_management_frame_master.sv */
`timescale 1ns / 1ps
`default_nettype none
// Clause 22 management frame master, one bit cell per tick transfer.
// Input channel (in_valid/in_ready): kind selects start read, start write,
// or tick. A start loads PHY address, register number and write data, and
// is ignored while a frame is running. Each tick during a frame yields one
// bit cell: drive level, drive enable, and the data_in sample at clock high.
// A read frame takes PREAMBLE_BITS+32 ticks and a write PREAMBLE_BITS+33.
// Output channel (out_valid/out_ready): exactly one result per input
// transfer, carrying the cell, busy and done flags, and on the last cell of
// a read the captured 16-bit word.
// The result is registered: it is on the output register in the cycle after the input transfer.
// Throughput: one transfer per cycle unless the output stalls; the frame
// counter and shift registers update in the same cycle as the transfer.
// Stall: while a result waits and out_ready is low, in_ready drops, so the
// input side holds; as soon as the result is taken a new item enters.
// Reset: clears the output valid flag and returns the frame logic to idle.
module mdio_management_frame_master
	import mmfm_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output      logic               in_ready,
	input  wire logic [1:0]         kind,
	input  wire logic [4:0]         phy_address,
	input  wire logic [4:0]         register_number,
	input  wire logic [DATA_W-1:0]  write_data,
	input  wire logic               data_in,
	output      logic               out_valid,
	input  wire logic               out_ready,
	output      logic               data_out,
	output      logic               drive_enable,
	output      logic               clock_active,
	output      logic               busy_res,
	output      logic               done_res,
	output      logic [DATA_W-1:0]  read_data
);

	// Frame state
	logic [CELL_W-1:0] cell_count_q, cell_count_nxt;
	logic              frame_busy_q, frame_busy_nxt;
	logic              is_write_q, is_write_nxt;
	logic [ADDR_W-1:0] address_shift_q, address_shift_nxt;
	logic [DATA_W-1:0] data_shift_q, data_shift_nxt;

	// Result register
	logic              out_valid_q;
	logic              data_out_q, drive_enable_q, clock_active_q, busy_q, done_q;
	logic [DATA_W-1:0] read_data_q;

	// Combinational result of the current item
	logic              dout, den, clk_act, done;
	logic [DATA_W-1:0] rdata;
	logic [3:0]        addr_off, wr_off;
	logic [3:0]        addr_idx, wr_idx;
	logic [CELL_W-1:0] last_cell;
	logic              accept;

	// Take a new item whenever the result register is free or being drained
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// Offsets only matter inside their field, so four bits are enough
	assign addr_off  = cell_count_q[3:0] - CELL_ADDR_LO[3:0];
	assign wr_off    = cell_count_q[3:0] - CELL_WR_LO[3:0];
	assign addr_idx  = 4'd9 - addr_off;
	assign wr_idx    = 4'd15 - wr_off;
	assign last_cell = is_write_q ? CELL_WR_LAST : CELL_RD_LAST;

	always_comb begin
		cell_count_nxt    = cell_count_q;
		frame_busy_nxt    = frame_busy_q;
		is_write_nxt      = is_write_q;
		address_shift_nxt = address_shift_q;
		data_shift_nxt    = data_shift_q;
		dout    = 1'b0;
		den     = 1'b0;
		clk_act = 1'b0;
		done    = 1'b0;
		rdata   = '0;
		unique case (kind_t'(kind))
			KIND_READ, KIND_WRITE: begin
				// Load a request only when no frame is running
				if (!frame_busy_q) begin
					frame_busy_nxt    = 1'b1;
					is_write_nxt      = kind[0];
					cell_count_nxt    = '0;
					address_shift_nxt = {phy_address, register_number};
					data_shift_nxt    = kind[0] ? write_data : '0;
				end
			end
			KIND_TICK: begin
				if (frame_busy_q) begin
					clk_act = 1'b1;
					priority if (cell_count_q < CELL_START0) begin
						dout = 1'b1;
						den  = 1'b1;
					end else if (cell_count_q == CELL_START0) begin
						den  = 1'b1;
					end else if (cell_count_q == CELL_START1) begin
						dout = 1'b1;
						den  = 1'b1;
					end else if (cell_count_q == CELL_OP0) begin
						dout = !is_write_q;
						den  = 1'b1;
					end else if (cell_count_q == CELL_OP1) begin
						dout = is_write_q;
						den  = 1'b1;
					end else if (cell_count_q <= CELL_ADDR_HI) begin
						dout = address_shift_q[addr_idx];
						den  = 1'b1;
					end else if (is_write_q) begin
						if (cell_count_q >= CELL_WR_LO && cell_count_q <= CELL_WR_HI) begin
							dout = data_shift_q[wr_idx];
							den  = 1'b1;
						end
					end else begin
						// Shift in the PHY's read word, MSB first
						if (cell_count_q >= CELL_RD_LO && cell_count_q <= CELL_RD_HI)
							data_shift_nxt = {data_shift_q[DATA_W-2:0], data_in};
					end
					if (cell_count_q >= last_cell) begin
						done           = 1'b1;
						rdata          = is_write_q ? '0 : data_shift_nxt;
						frame_busy_nxt = 1'b0;
						cell_count_nxt = '0;
					end else begin
						cell_count_nxt = cell_count_q + CELL_W'(1);
					end
				end
			end
			default: begin
				// Unused kind: idle item, state held
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_count_q    <= '0;
			frame_busy_q    <= 1'b0;
			is_write_q      <= 1'b0;
			address_shift_q <= '0;
			data_shift_q    <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (accept) begin
				cell_count_q    <= cell_count_nxt;
				frame_busy_q    <= frame_busy_nxt;
				is_write_q      <= is_write_nxt;
				address_shift_q <= address_shift_nxt;
				data_shift_q    <= data_shift_nxt;
				out_valid_q     <= 1'b1;
			end else if (out_ready) begin
				out_valid_q     <= 1'b0;
			end
		end
	end

	// Result payload needs no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			data_out_q     <= dout;
			drive_enable_q <= den;
			clock_active_q <= clk_act;
			busy_q         <= frame_busy_nxt;
			done_q         <= done;
			read_data_q    <= rdata;
		end
	end

	assign out_valid    = out_valid_q;
	assign data_out     = data_out_q;
	assign drive_enable = drive_enable_q;
	assign clock_active = clock_active_q;
	assign busy_res     = busy_q;
	assign done_res     = done_q;
	assign read_data    = read_data_q;

endmodule
`default_nettype wire
